@@ rtl/core/toy_cpu_instruction_step_macros.svh @@
// ----------------------------------------------------------------------------
// toy cpu instruction step - assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef TOY_CPU_INSTRUCTION_STEP_MACROS_SVH
`define TOY_CPU_INSTRUCTION_STEP_MACROS_SVH

// same-cycle implication
`define TCIS_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TCIS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/tcis_pkg.sv @@
// ----------------------------------------------------------------------------
// tcis_pkg
// item types, opcodes and compare codes of the toy cpu instruction step block
// ----------------------------------------------------------------------------
package tcis_pkg;

	// default sizes
	localparam int MEM_DEPTH_DEF = 256;
	localparam int NUM_REGS_DEF  = 16;
	localparam int REG_WIDTH_DEF = 8;

	// opcodes
	localparam logic [7:0] OP_NOP  = 8'h00;
	localparam logic [7:0] OP_ADD  = 8'h01;
	localparam logic [7:0] OP_SUB  = 8'h02;
	localparam logic [7:0] OP_LD   = 8'h03;
	localparam logic [7:0] OP_JMP  = 8'h04;
	localparam logic [7:0] OP_CMP  = 8'h05;
	localparam logic [7:0] OP_JE   = 8'h06;
	localparam logic [7:0] OP_JGT  = 8'h08;
	localparam logic [7:0] OP_JLT  = 8'h09;
	localparam logic [7:0] OP_INC  = 8'h0a;
	localparam logic [7:0] OP_DEC  = 8'h0b;
	localparam logic [7:0] OP_OUT  = 8'h0c;
	localparam logic [7:0] OP_HALT = 8'h0d;

	// compare codes
	localparam logic [1:0] CMP_EQ = 2'd0;
	localparam logic [1:0] CMP_GT = 2'd1;
	localparam logic [1:0] CMP_LT = 2'd2;

	// input item
	typedef struct packed {
		logic       mode;
		logic [7:0] load_addr;
		logic [7:0] load_data;
	} cmd_t;

	// result item
	typedef struct packed {
		logic       out_valid;
		logic [7:0] out_value;
		logic [7:0] pc_after;
		logic [7:0] opcode_seen;
		logic       halted;
		logic       bad_opcode;
		logic [1:0] compare_code;
	} res_t;

endpackage

@@ rtl/core/toy_cpu_instruction_step.sv @@
// ----------------------------------------------------------------------------
// toy_cpu_instruction_step
// byte-coded processor: load items fill the program memory, step items run
// one instruction each against a memory-held register file
// ----------------------------------------------------------------------------
//
// channel | dir | handshake            | payload
// --------+-----+----------------------+-------------------------------
// cmd     | in  | cmd_valid, cmd_stall | tcis_pkg::cmd_t (mode, load_addr, load_data)
// res     | out | res_valid, res_stall | tcis_pkg::res_t (one result per item)
//
// steps per item, counted from the engine taking it from the input buffer:
//   load or halted step finish in idle, nop / halt / unknown opcode in F1, jumps
//   in F2, ld / add / sub / inc / dec / out in EX, cmp in CMP; set by one program
//   memory access per cycle for the opcode and operand fetches, and by the single
//   register file read port (cmp reads two registers in turn)
// a one-entry input buffer takes the next item while the engine works, and
//   the result register holds a finished item while the engine goes on
// reset clears all control state; per-entry valid bits make the program
//   memory and register file read as zero until written, so no clearing pass
// a stall on res holds the engine at its final step; no state is committed
//   until the result register can take the item
//
module toy_cpu_instruction_step #(
	parameter int MEM_DEPTH = tcis_pkg::MEM_DEPTH_DEF,
	parameter int NUM_REGS  = tcis_pkg::NUM_REGS_DEF,
	parameter int REG_WIDTH = tcis_pkg::REG_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  tcis_pkg::cmd_t  cmd,
	output logic            res_valid,
	input  logic            res_stall,
	output tcis_pkg::res_t  res
);
	import tcis_pkg::*;

	`include "toy_cpu_instruction_step_macros.svh"

	// address and index widths
	localparam int AW  = $clog2(MEM_DEPTH);
	localparam int PCW = AW + 1;
	localparam int RIW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam logic [PCW-1:0] DEPTH_W = PCW'(MEM_DEPTH);

	// byte modulo via reciprocal multiply, exact for 8-bit values
	localparam int RECIP_SH  = 17;
	localparam int MEM_RECIP = ((1 << RECIP_SH) + MEM_DEPTH - 1) / MEM_DEPTH;
	localparam int REG_RECIP = ((1 << RECIP_SH) + NUM_REGS - 1) / NUM_REGS;

	// engine states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_F1   = 3'd1;  // opcode in read data
	localparam logic [2:0] ST_F2   = 3'd2;  // first operand in read data
	localparam logic [2:0] ST_EX   = 3'd3;  // second operand and r[a0] ready
	localparam logic [2:0] ST_CMP  = 3'd4;  // r[a1] ready

	function automatic logic [AW-1:0] mem_wrap(input logic [7:0] v);
		logic [25:0] prod;
		logic [8:0]  quo;
		logic [16:0] rem;
		prod = 26'(v) * 26'(MEM_RECIP);
		quo  = prod[25:RECIP_SH];
		rem  = 17'(v) - 17'(quo) * 17'(MEM_DEPTH);
		return rem[AW-1:0];
	endfunction

	function automatic logic [RIW-1:0] reg_wrap(input logic [7:0] v);
		logic [25:0] prod;
		logic [8:0]  quo;
		logic [16:0] rem;
		prod = 26'(v) * 26'(REG_RECIP);
		quo  = prod[25:RECIP_SH];
		rem  = 17'(v) - 17'(quo) * 17'(NUM_REGS);
		return rem[RIW-1:0];
	endfunction

	// pc advance by one to three, wrapping at the memory depth
	function automatic logic [AW-1:0] pc_inc(input logic [AW-1:0] a, input logic [1:0] k);
		logic [PCW-1:0] s;
		s = {1'b0, a} + PCW'(k);
		if (s >= DEPTH_W) begin
			s = s - DEPTH_W;
		end
		return s[AW-1:0];
	endfunction

	// architectural state
	logic [2:0]           state_q, state_nxt;
	logic [AW-1:0]        pc_q, pc_nxt;
	logic [1:0]           cmp_q, cmp_nxt;
	logic                 halt_q, halt_nxt;

	// working registers of the instruction in flight
	logic [7:0]           op_q;
	logic [7:0]           a0_q;
	logic [REG_WIDTH-1:0] ra_q;
	logic                 op_ld, a0_ld, ra_ld;

	// input buffer and result register
	cmd_t                 in_q;
	logic                 in_full_q;
	res_t                 res_q, res_nxt;
	logic                 res_vld_q;
	logic                 take, fire, out_free;

	// program memory, one port
	logic [7:0]           pm_mem [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] pm_vld_q;
	logic [7:0]           pm_rdata_q;
	logic                 pm_rvld_q;
	logic                 pm_we, pm_re;
	logic [AW-1:0]        pm_addr;
	logic [7:0]           pm_rd;

	// register file, one read and one write port
	logic [REG_WIDTH-1:0] rf_mem [NUM_REGS];
	logic [NUM_REGS-1:0]  rf_vld_q;
	logic [REG_WIDTH-1:0] rf_rdata_q;
	logic                 rf_rvld_q;
	logic                 rf_re, rf_we;
	logic [RIW-1:0]       rf_raddr, rf_waddr;
	logic [REG_WIDTH-1:0] rf_wdata;
	logic [REG_WIDTH-1:0] rf_rd;

	// entries never written read as zero
	assign pm_rd = pm_rvld_q ? pm_rdata_q : 8'h00;
	assign rf_rd = rf_rvld_q ? rf_rdata_q : '0;

	assign out_free  = !res_vld_q || !res_stall;
	assign cmd_stall = in_full_q && !take;
	assign res_valid = res_vld_q;
	assign res       = res_q;

	// ---------------------------------------------------------------------------
	// engine control
	// ---------------------------------------------------------------------------
	always_comb begin
		state_nxt = state_q;
		pc_nxt    = pc_q;
		cmp_nxt   = cmp_q;
		halt_nxt  = halt_q;
		take      = 1'b0;
		fire      = 1'b0;
		op_ld     = 1'b0;
		a0_ld     = 1'b0;
		ra_ld     = 1'b0;
		pm_we     = 1'b0;
		pm_re     = 1'b0;
		pm_addr   = pc_q;
		rf_re     = 1'b0;
		rf_raddr  = reg_wrap(a0_q);
		rf_we     = 1'b0;
		rf_waddr  = reg_wrap(a0_q);
		rf_wdata  = rf_rd;
		res_nxt   = '0;

		case (state_q)
			ST_IDLE: begin
				if (in_full_q) begin
					if (!in_q.mode) begin
						// load item: write the byte, report unchanged state
						if (out_free) begin
							take    = 1'b1;
							fire    = 1'b1;
							pm_we   = 1'b1;
							pm_addr = mem_wrap(in_q.load_addr);
						end
					end else if (halt_q) begin
						// halted step: no fetch
						if (out_free) begin
							take = 1'b1;
							fire = 1'b1;
						end
					end else begin
						take      = 1'b1;
						pm_re     = 1'b1;
						pm_addr   = pc_q;
						state_nxt = ST_F1;
					end
				end
			end

			ST_F1: begin
				res_nxt.opcode_seen = pm_rd;
				case (pm_rd)
					OP_NOP: begin
						if (out_free) begin
							fire      = 1'b1;
							pc_nxt    = pc_inc(pc_q, 2'd1);
							state_nxt = ST_IDLE;
						end
					end
					OP_HALT: begin
						if (out_free) begin
							fire      = 1'b1;
							halt_nxt  = 1'b1;
							state_nxt = ST_IDLE;
						end
					end
					OP_ADD, OP_SUB, OP_LD, OP_JMP, OP_CMP, OP_JE, OP_JGT, OP_JLT,
					OP_INC, OP_DEC, OP_OUT: begin
						op_ld     = 1'b1;
						pm_re     = 1'b1;
						pm_addr   = pc_inc(pc_q, 2'd1);
						state_nxt = ST_F2;
					end
					default: begin
						// unknown opcode: pc stays
						if (out_free) begin
							fire               = 1'b1;
							res_nxt.bad_opcode = 1'b1;
							state_nxt          = ST_IDLE;
						end
					end
				endcase
			end

			ST_F2: begin
				res_nxt.opcode_seen = op_q;
				case (op_q)
					OP_JMP, OP_JE, OP_JGT, OP_JLT: begin
						if (out_free) begin
							fire      = 1'b1;
							state_nxt = ST_IDLE;
							if ((op_q == OP_JMP) ||
								((op_q == OP_JE) && (cmp_q == CMP_EQ)) ||
								((op_q == OP_JGT) && (cmp_q == CMP_GT)) ||
								((op_q == OP_JLT) && (cmp_q == CMP_LT))) begin
								pc_nxt = mem_wrap(pm_rd);
							end else begin
								pc_nxt = pc_inc(pc_q, 2'd2);
							end
						end
					end
					default: begin
						// fetch the second operand and r[a0] together
						a0_ld     = 1'b1;
						pm_re     = 1'b1;
						pm_addr   = pc_inc(pc_q, 2'd2);
						rf_re     = 1'b1;
						rf_raddr  = reg_wrap(pm_rd);
						state_nxt = ST_EX;
					end
				endcase
			end

			ST_EX: begin
				res_nxt.opcode_seen = op_q;
				if (op_q == OP_CMP) begin
					ra_ld     = 1'b1;
					rf_re     = 1'b1;
					rf_raddr  = reg_wrap(pm_rd);
					state_nxt = ST_CMP;
				end else if (out_free) begin
					fire      = 1'b1;
					state_nxt = ST_IDLE;
					case (op_q)
						OP_ADD: begin
							rf_we    = 1'b1;
							rf_wdata = rf_rd + REG_WIDTH'(pm_rd);
							pc_nxt   = pc_inc(pc_q, 2'd3);
						end
						OP_SUB: begin
							rf_we    = 1'b1;
							rf_wdata = rf_rd - REG_WIDTH'(pm_rd);
							pc_nxt   = pc_inc(pc_q, 2'd3);
						end
						OP_LD: begin
							rf_we    = 1'b1;
							rf_wdata = REG_WIDTH'(pm_rd);
							pc_nxt   = pc_inc(pc_q, 2'd3);
						end
						OP_INC: begin
							rf_we    = 1'b1;
							rf_wdata = rf_rd + REG_WIDTH'(1);
							pc_nxt   = pc_inc(pc_q, 2'd2);
						end
						OP_DEC: begin
							rf_we    = 1'b1;
							rf_wdata = rf_rd - REG_WIDTH'(1);
							pc_nxt   = pc_inc(pc_q, 2'd2);
						end
						OP_OUT: begin
							res_nxt.out_valid = 1'b1;
							res_nxt.out_value = rf_rd[7:0];
							pc_nxt            = pc_inc(pc_q, 2'd2);
						end
						default: begin
							pc_nxt = pc_q;
						end
					endcase
				end
			end

			ST_CMP: begin
				res_nxt.opcode_seen = op_q;
				if (out_free) begin
					fire      = 1'b1;
					state_nxt = ST_IDLE;
					pc_nxt    = pc_inc(pc_q, 2'd3);
					if (ra_q == rf_rd) begin
						cmp_nxt = CMP_EQ;
					end else if (ra_q > rf_rd) begin
						cmp_nxt = CMP_GT;
					end else begin
						cmp_nxt = CMP_LT;
					end
				end
			end

			default: begin
				state_nxt = ST_IDLE;
			end
		endcase

		res_nxt.pc_after     = 8'(pc_nxt);
		res_nxt.halted       = halt_nxt;
		res_nxt.compare_code = cmp_nxt;
	end

	// ---------------------------------------------------------------------------
	// control registers
	// ---------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pc_q      <= '0;
			cmp_q     <= CMP_EQ;
			halt_q    <= 1'b0;
			in_full_q <= 1'b0;
			res_vld_q <= 1'b0;
			pm_vld_q  <= '0;
			pm_rvld_q <= 1'b0;
			rf_vld_q  <= '0;
			rf_rvld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			// architectural state commits only with the result
			if (fire) begin
				pc_q   <= pc_nxt;
				cmp_q  <= cmp_nxt;
				halt_q <= halt_nxt;
			end
			if (cmd_valid && !cmd_stall) begin
				in_full_q <= 1'b1;
			end else if (take) begin
				in_full_q <= 1'b0;
			end
			if (fire) begin
				res_vld_q <= 1'b1;
			end else if (!res_stall) begin
				res_vld_q <= 1'b0;
			end
			if (pm_we) begin
				pm_vld_q[pm_addr] <= 1'b1;
			end
			if (pm_re) begin
				pm_rvld_q <= pm_vld_q[pm_addr];
			end
			if (rf_we) begin
				rf_vld_q[rf_waddr] <= 1'b1;
			end
			if (rf_re) begin
				rf_rvld_q <= rf_vld_q[rf_raddr];
			end
		end
	end

	// ---------------------------------------------------------------------------
	// payload registers
	// ---------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			in_q <= cmd;
		end
		if (fire) begin
			res_q <= res_nxt;
		end
		if (op_ld) begin
			op_q <= pm_rd;
		end
		if (a0_ld) begin
			a0_q <= pm_rd;
		end
		if (ra_ld) begin
			ra_q <= rf_rd;
		end
	end

	// ---------------------------------------------------------------------------
	// memories
	// ---------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (pm_we) begin
			pm_mem[pm_addr] <= in_q.load_data;
		end
		if (pm_re) begin
			pm_rdata_q <= pm_mem[pm_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_mem[rf_waddr] <= rf_wdata;
		end
		if (rf_re) begin
			rf_rdata_q <= rf_mem[rf_raddr];
		end
	end

	// ---------------------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------------------
	`TCIS_ASSERT_NEXT(a_halt_sticky, halt_q, halt_q, "halt flag dropped without reset")
	`TCIS_ASSERT_IMPLY(a_pm_single_port, pm_we, !pm_re, "program memory read and write together")
	`TCIS_ASSERT_IMPLY(a_load_from_idle, pm_we, (state_q == ST_IDLE) && take && fire, "load write outside idle")
	`TCIS_ASSERT_IMPLY(a_pc_range, 1'b1, {1'b0, pc_q} < DEPTH_W, "pc beyond memory depth")
	`TCIS_ASSERT_IMPLY(a_cmp_code, 1'b1, (cmp_q == CMP_EQ) || (cmp_q == CMP_GT) || (cmp_q == CMP_LT), "bad compare code")
	`TCIS_ASSERT_NEXT(a_fire_shows, fire, res_vld_q, "finished item not presented")

endmodule

@@ tb/tb_toy_cpu_instruction_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_toy_cpu_instruction_step
// self-checking bench: loads byte programs and steps them, predicting every
// result with a shadow copy of memory, registers, pc and flags
// ----------------------------------------------------------------------------
module tb_toy_cpu_instruction_step;
	import tcis_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 30;
	localparam int RANDOM_ITEMS   = 1100;

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd_item;
	logic res_valid;
	logic res_stall;
	res_t res_item;

	// shadow cpu state
	logic [7:0] shadow_mem [256];
	logic [7:0] shadow_regs [16];
	logic [7:0] shadow_pc;
	logic [1:0] shadow_cmp;
	logic       shadow_halt;

	res_t pending_results [$];
	int   mismatch_count = 0;
	int   items_sent = 0;

	// sender burst control
	int burst_left = 0;
	bit gaps_on = 1'b1;

	// receiver stall pattern
	int stall_phase_left = 0;
	int stall_pct = 0;

	// every opcode except halt, which is sticky and only used at the very end
	logic [7:0] running_ops [12] = '{OP_NOP, OP_ADD, OP_SUB, OP_LD, OP_JMP, OP_CMP,
		OP_JE, OP_JGT, OP_JLT, OP_INC, OP_DEC, OP_OUT};

	toy_cpu_instruction_step u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res_item)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	function automatic void clear_shadow();
		for (int i = 0; i < 256; i++) shadow_mem[i] = 8'h00;
		for (int i = 0; i < 16; i++) shadow_regs[i] = 8'h00;
		shadow_pc   = 8'h00;
		shadow_cmp  = CMP_EQ;
		shadow_halt = 1'b0;
	endfunction

	// runs one item on the shadow state and returns the result it gives
	function automatic res_t execute_item(input cmd_t item);
		res_t       r;
		logic [7:0] op;
		logic [7:0] a0;
		logic [7:0] a1;
		logic [7:0] nxt;
		logic [7:0] x;
		logic [7:0] y;
		r = '0;
		if (!item.mode) begin
			// loads land even while halted
			shadow_mem[item.load_addr] = item.load_data;
		end else if (!shadow_halt) begin
			op  = shadow_mem[shadow_pc];
			nxt = shadow_pc + 8'd1;
			a0  = shadow_mem[nxt];
			nxt = shadow_pc + 8'd2;
			a1  = shadow_mem[nxt];
			nxt = shadow_pc;
			case (op)
				OP_NOP: nxt = shadow_pc + 8'd1;
				OP_ADD: begin
					shadow_regs[a0[3:0]] = shadow_regs[a0[3:0]] + a1;
					nxt = shadow_pc + 8'd3;
				end
				OP_SUB: begin
					shadow_regs[a0[3:0]] = shadow_regs[a0[3:0]] - a1;
					nxt = shadow_pc + 8'd3;
				end
				OP_LD: begin
					shadow_regs[a0[3:0]] = a1;
					nxt = shadow_pc + 8'd3;
				end
				OP_JMP: nxt = a0;
				OP_CMP: begin
					x = shadow_regs[a0[3:0]];
					y = shadow_regs[a1[3:0]];
					shadow_cmp = (x == y) ? CMP_EQ : ((x > y) ? CMP_GT : CMP_LT);
					nxt = shadow_pc + 8'd3;
				end
				OP_JE:  nxt = (shadow_cmp == CMP_EQ) ? a0 : shadow_pc + 8'd2;
				OP_JGT: nxt = (shadow_cmp == CMP_GT) ? a0 : shadow_pc + 8'd2;
				OP_JLT: nxt = (shadow_cmp == CMP_LT) ? a0 : shadow_pc + 8'd2;
				OP_INC: begin
					shadow_regs[a0[3:0]] = shadow_regs[a0[3:0]] + 8'd1;
					nxt = shadow_pc + 8'd2;
				end
				OP_DEC: begin
					shadow_regs[a0[3:0]] = shadow_regs[a0[3:0]] - 8'd1;
					nxt = shadow_pc + 8'd2;
				end
				OP_OUT: begin
					r.out_valid = 1'b1;
					r.out_value = shadow_regs[a0[3:0]];
					nxt = shadow_pc + 8'd2;
				end
				OP_HALT: shadow_halt = 1'b1;
				default: r.bad_opcode = 1'b1;
			endcase
			shadow_pc     = nxt;
			r.opcode_seen = op;
		end
		r.pc_after     = shadow_pc;
		r.halted       = shadow_halt;
		r.compare_code = shadow_cmp;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// item builders and program generation helpers
	// ------------------------------------------------------------------------

	function automatic cmd_t load_item(input logic [7:0] addr, input logic [7:0] data);
		cmd_t c;
		c.mode      = 1'b0;
		c.load_addr = addr;
		c.load_data = data;
		return c;
	endfunction

	// load fields are don't-care in a step, so they carry random bits
	function automatic cmd_t step_item();
		cmd_t c;
		c.mode      = 1'b1;
		c.load_addr = 8'($urandom_range(0, 255));
		c.load_data = 8'($urandom_range(0, 255));
		return c;
	endfunction

	function automatic int op_length(input logic [7:0] op);
		case (op)
			OP_ADD, OP_SUB, OP_LD, OP_CMP: return 3;
			OP_JMP, OP_JE, OP_JGT, OP_JLT, OP_INC, OP_DEC, OP_OUT: return 2;
			default: return 1;
		endcase
	endfunction

	function automatic logic [7:0] unknown_op();
		logic [7:0] v;
		do begin
			v = 8'($urandom_range(0, 255));
		end while (v <= OP_HALT && v != 8'h07);
		return v;
	endfunction

	// mostly a few low registers so compares often see related values;
	// upper bits random to exercise index wrap
	function automatic logic [7:0] reg_operand();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 9) < 7) b[3:0] = 4'($urandom_range(0, 3));
		return b;
	endfunction

	function automatic logic [7:0] value_operand();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'h01;
			2: return 8'hff;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// channel handling
	// ------------------------------------------------------------------------

	// called at a rising edge; returns at the edge that accepts the item
	task automatic send_cmd(input cmd_t item);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (gaps_on) begin
				gap = $urandom_range(0, 5);
				if (gap != 0) begin
					cmd_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		burst_left--;
		pending_results.push_back(execute_item(item));
		cmd_item  <= item;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic drain_results();
		cmd_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic note_mismatch(input string what, input logic [7:0] want,
		input logic [7:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch %s: expected %02h got %02h at %0t", what, want, got, $realtime);
	endtask

	task automatic check_field(input string what, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) note_mismatch(what, want, got);
	endtask

	// receiver: phases of random length, each with its own stall density
	always @(posedge clk) begin
		if (stall_phase_left == 0) begin
			stall_phase_left = $urandom_range(16, 160);
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 20;
				2: stall_pct = 50;
				default: stall_pct = 85;
			endcase
		end else begin
			stall_phase_left--;
		end
		res_stall <= ($urandom_range(1, 100) <= stall_pct);
	end

	// result checker: compare each accepted result with the oldest prediction
	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				note_mismatch("unexpected result, pc_after", 8'h00, res_item.pc_after);
			end else begin
				want = pending_results.pop_front();
				check_field("out_valid", 8'(want.out_valid), 8'(res_item.out_valid));
				check_field("out_value", want.out_value, res_item.out_value);
				check_field("pc_after", want.pc_after, res_item.pc_after);
				check_field("opcode_seen", want.opcode_seen, res_item.opcode_seen);
				check_field("halted", 8'(want.halted), 8'(res_item.halted));
				check_field("bad_opcode", 8'(want.bad_opcode), 8'(res_item.bad_opcode));
				check_field("compare_code", 8'(want.compare_code), 8'(res_item.compare_code));
			end
		end
	end

	// watchdog: too long without any item moving on either channel
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("toy_cpu_instruction_step regression: fail");
		$finish;
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// hand-built program run from reset: every data opcode but sub, taken and
	// untaken jumps, register index wrap, arithmetic wrap both ways, a jump
	// through the last address and an unknown opcode that pins the pc
	task automatic test_directed_program();
		logic [15:0] image [$];
		image = '{16'h0003, 16'h0105, 16'h02ff, 16'h0301, 16'h0405, 16'h0502,
			16'h060b, 16'h0716, 16'h080a, 16'h0a0c, 16'h0b06, 16'h0c00,
			16'h0d05, 16'h0e06, 16'h1008, 16'h11fe, 16'hfe04, 16'hff14,
			16'h1406, 16'h1516, 16'h1605, 16'h1906, 16'h1aff};
		foreach (image[i]) send_cmd(load_item(image[i][15:8], image[i][7:0]));
		// ld add dec inc out nop cmp jgt jmp je cmp je, then the unknown twice
		repeat (14) send_cmd(step_item());
		drain_results();
	endtask

	// random programs written at the current pc and then stepped, with some
	// truncated programs and stray items mixed in
	task automatic test_random_programs();
		logic [7:0] ops [$];
		int         offs [$];
		logic [7:0] prog [$];
		logic [7:0] base;
		int         start_count;
		int         n_instr;
		int         len;
		int         n_load;
		int         n_steps;
		start_count = items_sent;
		while (items_sent - start_count < RANDOM_ITEMS) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 99) < 15) begin
				// stray items anywhere in memory
				repeat ($urandom_range(1, 6)) begin
					if ($urandom_range(0, 1))
						send_cmd(step_item());
					else
						send_cmd(load_item(8'($urandom_range(0, 255)),
							8'($urandom_range(0, 255))));
				end
			end else begin
				ops.delete();
				offs.delete();
				prog.delete();
				base    = shadow_pc;
				n_instr = $urandom_range(3, 10);
				len     = 0;
				for (int i = 0; i < n_instr; i++) begin
					if ($urandom_range(0, 99) < 4)
						ops.push_back(unknown_op());
					else
						ops.push_back(running_ops[$urandom_range(0, 11)]);
					offs.push_back(len);
					len += op_length(ops[i]);
				end
				foreach (ops[i]) begin
					prog.push_back(ops[i]);
					case (ops[i])
						OP_ADD, OP_SUB, OP_LD: begin
							prog.push_back(reg_operand());
							prog.push_back(value_operand());
						end
						OP_CMP: begin
							prog.push_back(reg_operand());
							prog.push_back(reg_operand());
						end
						OP_JMP, OP_JE, OP_JGT, OP_JLT: begin
							// mostly back into the program so loops form
							if ($urandom_range(0, 9) < 7)
								prog.push_back(base + 8'(offs[$urandom_range(0, n_instr - 1)]));
							else
								prog.push_back(8'($urandom_range(0, 255)));
						end
						OP_INC, OP_DEC, OP_OUT: prog.push_back(reg_operand());
						default: ;
					endcase
				end
				// now and then a program is cut short
				n_load = ($urandom_range(0, 9) == 0) ? $urandom_range(1, prog.size()) :
					prog.size();
				for (int i = 0; i < n_load; i++)
					send_cmd(load_item(base + 8'(i), prog[i]));
				n_steps = $urandom_range(n_instr, 2 * n_instr + 4);
				repeat (n_steps) send_cmd(step_item());
			end
		end
		gaps_on = 1'b1;
		drain_results();
	endtask

	// halt is sticky: later steps do nothing, loads still write memory
	task automatic test_halt_sticky();
		send_cmd(load_item(shadow_pc, OP_HALT));
		send_cmd(step_item());
		send_cmd(step_item());
		send_cmd(load_item(shadow_pc, OP_OUT));
		send_cmd(load_item(8'hff, 8'hff));
		send_cmd(step_item());
		send_cmd(step_item());
		drain_results();
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------

	initial begin
		cmd_valid = 1'b0;
		cmd_item  = '0;
		res_stall = 1'b0;
		arst_n    = 1'b0;
		clear_shadow();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_program();
		test_random_programs();
		test_halt_sticky();

		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("toy_cpu_instruction_step regression: pass");
		end else begin
			$display("toy_cpu_instruction_step regression: fail");
		end
		$finish;
	end

endmodule
